/* design/assert_macros.svh */
// assertion helpers used by gbde_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/gbde_pkg.sv */
package gbde_pkg;

   localparam int MaxNodesDefault   = 64;
   localparam int MaxEntriesDefault = 256;

   localparam int VertexWidth = 6;
   localparam int CfgWidth    = 7;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_BFS   = 2'd2,
      REQ_DFS   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_VISITED = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   // classified command from front to back
   typedef struct packed {
      logic                     error;
      status_type               err_code;
      req_kind_type             kind;
      logic [VertexWidth-1:0]   first_vertex;
      logic [VertexWidth-1:0]   second_vertex;
   } cmd_type;

   typedef struct packed {
      logic [VertexWidth-1:0] visited_vertex;
      status_type             status;
      logic                   last;
   } result_type;

endpackage

/* design/graph_bfs_dfs_engine.sv */
// channel   | dir | tdata (low bit first)                     | tuser
// req_      | in  | req_type[1:0], first_vertex, second_vertex | -
// rsp_      | out | visited_vertex[5:0], status[1:0]           | - (tlast = last)
// csr_      | in  | num_vertices[6:0]                          | -
// breadth-first: each vertex passes the pop, head, list and entry states, and each edge
// entry walked passes the entry and check states; depth-first steps are set by the
// registered reads of the list, entry and stack stores
// an add writes its two list entries in the add1 and add2 states; clear and error requests finish in idle
// reset is synchronous; the graph is empty after reset
// a stalled result holds the back part; the front keeps queuing two requests
module graph_bfs_dfs_engine #(
   parameter int MaxNodes   = gbde_pkg::MaxNodesDefault,
   parameter int MaxEntries = gbde_pkg::MaxEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // req_type, first_vertex, second_vertex
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // visited_vertex, status
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);
   import gbde_pkg::*;

   logic [6:0]      nv_ff;
   logic [6:0]      limit;
   logic [2:0][5:0] fields;
   logic            cmd_valid, cmd_ready;
   cmd_type         cmd;
   result_type      res;

   // register write
   always_ff @(posedge clock) begin
      if (reset) nv_ff <= 7'd64;
      else if (csr_we) nv_ff <= csr_wdata;
   end

   assign limit     = (nv_ff > 7'(MaxNodes)) ? 7'(MaxNodes) : nv_ff;
   assign fields[0] = {4'd0, req_tdata[1:0]};
   assign fields[1] = req_tdata[7:2];
   assign fields[2] = req_tdata[13:8];

   gbde_front u_front (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_fields(fields), .limit,
      .cmd_valid, .cmd_ready, .cmd
   );

   gbde_back #(.MaxNodes(MaxNodes), .MaxEntries(MaxEntries)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res
   );

   assign rsp_tdata = {res.status, res.visited_vertex};
   assign rsp_tlast = res.last;
endmodule

/* design/gbde_front.sv */
module gbde_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [2:0][5:0]          req_fields,
   input  logic [6:0]               limit,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output gbde_pkg::cmd_type        cmd
);
   import gbde_pkg::*;

   // two-entry queue towards the back part
   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;
   logic [1:0] kind;
   logic [5:0] va, vb;
   logic       a_bad, b_bad;

   assign kind  = req_fields[0][1:0];
   assign va    = req_fields[1];
   assign vb    = req_fields[2];
   assign a_bad = {1'b0, va} >= limit;
   assign b_bad = {1'b0, vb} >= limit;

   // classify a request
   always_comb begin
      q_in.kind          = req_kind_type'(kind);
      q_in.first_vertex  = va;
      q_in.second_vertex = vb;
      q_in.err_code      = ST_RANGE;
      q_in.error         = 1'b0;
      unique case (req_kind_type'(kind))
         REQ_CLEAR: q_in.error = 1'b0;
         REQ_ADD:   q_in.error = a_bad || b_bad;
         default:   q_in.error = a_bad;
      endcase
   end

   assign req_tready = count_ff != 2'd2;
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = count_ff != 2'd0;
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

/* design/gbde_back.sv */
`include "assert_macros.svh"
module gbde_back #(
   parameter int MaxNodes   = gbde_pkg::MaxNodesDefault,
   parameter int MaxEntries = gbde_pkg::MaxEntriesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  gbde_pkg::cmd_type     cmd,
   output logic                  res_valid,
   input  logic                  res_ready,
   output gbde_pkg::result_type  res
);
   import gbde_pkg::*;

   localparam int NW = $clog2(MaxNodes);
   localparam int PW = $clog2(MaxEntries) + 1;
   localparam int CW = $clog2(MaxNodes + 1);
   localparam logic [PW-1:0] Nil = PW'(MaxEntries);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_ADD1   = 12'b000000000010,
      S_ADD2   = 12'b000000000100,
      S_START  = 12'b000000001000,
      S_POP    = 12'b000000010000,
      S_HEAD   = 12'b000000100000,
      S_LIST   = 12'b000001000000,
      S_ENTRY  = 12'b000010000000,
      S_CHECK  = 12'b000100000000,
      S_TOP    = 12'b001000000000,
      S_PTR    = 12'b010000000000,
      S_PUSH   = 12'b100000000000
   } state_type;

   // memories
   logic [PW-1:0]          head_mem [MaxNodes];
   logic [VertexWidth-1:0] ev_mem   [MaxEntries];
   logic [PW-1:0]          en_mem   [MaxEntries];
   logic [VertexWidth-1:0] wv_mem   [MaxNodes];
   logic [PW-1:0]          wp_mem   [MaxNodes];
   logic [MaxNodes-1:0]    head_ok_ff;
   logic [MaxNodes-1:0]    mark_ff;

   state_type            state_ff;
   logic                 dfs_ff;
   logic [PW-1:0]        used_ff;
   logic [CW-1:0]        front_ff, rear_ff;
   logic [VertexWidth-1:0] va_ff, vb_ff, cur_ff;
   logic [PW-1:0]        p_ff;
   logic                 out_v_ff, out_v_in;
   result_type           out_ff, out_in;
   logic                 pend_v_ff, pend_v_in;
   logic [VertexWidth-1:0] pend_ff, pend_in;
   logic [PW-1:0]        head_rd_ff;
   logic                 head_ok_rd_ff;
   logic [VertexWidth-1:0] ev_rd_ff;
   logic [PW-1:0]        en_rd_ff;
   logic [VertexWidth-1:0] wv_rd_ff;
   logic [PW-1:0]        wp_rd_ff;
   logic                 stall;
   logic                 full;
   logic                 nb_ok;
   logic [NW-1:0]        head_addr;
   logic [PW-1:0]        head_val;
   logic                 emit, finish, reject;
   logic [VertexWidth-1:0] emit_vertex;

   assign stall     = out_v_ff && !res_ready;
   assign res_valid = out_v_ff;
   assign res       = out_ff;
   assign cmd_ready = state_ff == S_IDLE && !stall;
   assign full      = used_ff + PW'(2) > PW'(MaxEntries);
   assign head_val  = head_ok_rd_ff ? head_rd_ff : Nil;
   assign nb_ok     = {1'b0, ev_rd_ff} < (VertexWidth+1)'(MaxNodes)
                      && !mark_ff[NW'(ev_rd_ff)] && rear_ff < CW'(MaxNodes);

   // list head address for the read that the next state uses
   always_comb begin
      unique case (state_ff)
         S_IDLE:  head_addr = NW'(cmd.first_vertex);
         S_ADD1:  head_addr = NW'(vb_ff);
         S_HEAD:  head_addr = NW'(wv_rd_ff);
         default: head_addr = NW'(ev_rd_ff);
      endcase
   end

   // result events
   assign reject = state_ff == S_IDLE && cmd_valid
                   && (cmd.error || (cmd.kind == REQ_ADD && full));
   assign finish = (state_ff == S_POP && front_ff == rear_ff)
                   || (state_ff == S_TOP && rear_ff == CW'(0));

   always_comb begin
      emit        = 1'b0;
      emit_vertex = ev_rd_ff;
      if (state_ff == S_START && dfs_ff) begin
         emit        = 1'b1;
         emit_vertex = cur_ff;
      end else if (state_ff == S_HEAD) begin
         emit        = 1'b1;
         emit_vertex = wv_rd_ff;
      end else if (state_ff == S_CHECK && dfs_ff && nb_ok) begin
         emit = 1'b1;
      end
   end

   // each visit is held as pending until the next visit or the finish, so the final one can carry last
   always_comb begin
      out_v_in  = 1'b0;
      out_in    = out_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      if (emit) begin
         if (pend_v_ff) begin
            out_v_in = 1'b1;
            out_in   = '{visited_vertex: pend_ff, status: ST_VISITED, last: 1'b0};
         end
         pend_v_in = 1'b1;
         pend_in   = emit_vertex;
      end else if (finish) begin
         out_v_in  = 1'b1;
         out_in    = '{visited_vertex: pend_ff, status: ST_VISITED, last: 1'b1};
         pend_v_in = 1'b0;
      end else if (reject) begin
         out_v_in = 1'b1;
         out_in   = '{visited_vertex: '0,
                      status: cmd.error ? cmd.err_code : ST_FULL, last: 1'b1};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
      end else if (!stall) begin
         out_v_ff  <= out_v_in;
         out_ff    <= out_in;
         pend_v_ff <= pend_v_in;
         pend_ff   <= pend_in;
      end
   end

   // memory reads, registered
   always_ff @(posedge clock) begin
      if (!stall) begin
         head_rd_ff    <= head_mem[head_addr];
         head_ok_rd_ff <= head_ok_ff[head_addr];
         ev_rd_ff      <= ev_mem[p_ff[PW-2:0]];
         en_rd_ff      <= en_mem[p_ff[PW-2:0]];
         wv_rd_ff      <= wv_mem[NW'(front_ff)];
         wp_rd_ff      <= wp_mem[NW'(rear_ff - CW'(1))];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         used_ff    <= '0;
         head_ok_ff <= '0;
         mark_ff    <= '0;
         front_ff   <= '0;
         rear_ff    <= '0;
         dfs_ff     <= 1'b0;
      end else if (!stall) begin
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               va_ff  <= cmd.first_vertex;
               vb_ff  <= cmd.second_vertex;
               dfs_ff <= cmd.kind == REQ_DFS;
               if (cmd.kind == REQ_CLEAR) begin
                  head_ok_ff <= '0;
                  used_ff    <= '0;
               end else if (cmd.error) begin
                  state_ff <= S_IDLE;
               end else if (cmd.kind == REQ_ADD) begin
                  if (!full) state_ff <= S_ADD1;
               end else begin
                  mark_ff  <= MaxNodes'(1) << NW'(cmd.first_vertex);
                  cur_ff   <= cmd.first_vertex;
                  front_ff <= '0;
                  rear_ff  <= '0;
                  state_ff <= S_START;
               end
            end
            S_ADD1: begin
               ev_mem[used_ff[PW-2:0]] <= vb_ff;
               en_mem[used_ff[PW-2:0]] <= head_val;
               head_mem[NW'(va_ff)]    <= used_ff;
               head_ok_ff[NW'(va_ff)]  <= 1'b1;
               used_ff  <= used_ff + PW'(1);
               state_ff <= S_ADD2;
            end
            S_ADD2: begin
               // a self loop links onto the entry written in S_ADD1
               ev_mem[used_ff[PW-2:0]] <= va_ff;
               en_mem[used_ff[PW-2:0]] <= (va_ff == vb_ff) ? used_ff - PW'(1) : head_val;
               head_mem[NW'(vb_ff)]    <= used_ff;
               head_ok_ff[NW'(vb_ff)]  <= 1'b1;
               used_ff  <= used_ff + PW'(1);
               state_ff <= S_IDLE;
            end
            S_START: begin
               // start vertex goes into the queue or onto the stack
               wv_mem[NW'(rear_ff)] <= cur_ff;
               wp_mem[NW'(rear_ff)] <= head_val;
               rear_ff  <= rear_ff + CW'(1);
               state_ff <= dfs_ff ? S_TOP : S_POP;
            end
            S_POP: begin
               state_ff <= (front_ff == rear_ff) ? S_IDLE : S_HEAD;
            end
            S_HEAD: begin
               // bfs: wv_rd holds the dequeued vertex
               front_ff <= front_ff + CW'(1);
               state_ff <= S_LIST;
            end
            S_LIST: begin
               p_ff     <= head_val;
               state_ff <= S_ENTRY;
            end
            S_ENTRY: begin
               if (!dfs_ff && p_ff >= Nil) state_ff <= S_POP;
               else state_ff <= S_CHECK;
            end
            S_CHECK: begin
               p_ff <= en_rd_ff;
               if (dfs_ff) wp_mem[NW'(rear_ff - CW'(1))] <= en_rd_ff;
               if (nb_ok) begin
                  mark_ff[NW'(ev_rd_ff)] <= 1'b1;
                  if (!dfs_ff) begin
                     wv_mem[NW'(rear_ff)] <= ev_rd_ff;
                     rear_ff <= rear_ff + CW'(1);
                  end
               end
               if (dfs_ff) state_ff <= nb_ok ? S_PUSH : S_TOP;
               else state_ff <= S_ENTRY;
            end
            S_TOP: begin
               state_ff <= (rear_ff == CW'(0)) ? S_IDLE : S_PTR;
            end
            S_PTR: begin
               // dfs: wp_rd holds the top pointer
               if (wp_rd_ff >= Nil) begin
                  rear_ff  <= rear_ff - CW'(1);
                  state_ff <= S_TOP;
               end else begin
                  p_ff     <= wp_rd_ff;
                  state_ff <= S_ENTRY;
               end
            end
            S_PUSH: begin
               wp_mem[NW'(rear_ff)] <= head_val;
               rear_ff  <= rear_ff + CW'(1);
               state_ff <= S_TOP;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLY(a_used_bound, clock, reset, 1'b1, used_ff <= PW'(MaxEntries))
   `ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !cmd_ready)
   `ASSERT_NEXT(a_hold, clock, reset, res_valid && !res_ready, res_valid && $stable(res))
   `ASSERT_IMPLY(a_rear_bound, clock, reset, 1'b1, rear_ff <= CW'(MaxNodes))
endmodule
